// File: rtl/itff_pkg.sv
// Shared widths and types for the impedance tensor pipeline.
// No dependencies; every rtl file refers to it by scoped names.
package itff_pkg;

	localparam int FIELD_W = 64;
	localparam int HALF_W = 32;
	localparam int FRAC_W = 5;
	localparam logic [FRAC_W-1:0] FRAC_RESET = 5'd16;

	// exact widths: complex cross difference, wide product, product sum
	localparam int SUM_W = 66;
	localparam int PROD_W = 132;
	localparam int X_W = 133;
	localparam int MAG_W = 131;
	// dividend after the fraction shift, with room for den << 32
	localparam int DIV_W = MAG_W + HALF_W + 1;

	typedef struct packed {
		logic signed [SUM_W-1:0] re;
		logic signed [SUM_W-1:0] im;
	} cwide_t;

endpackage

// File: rtl/itff_cross.sv
// Two-stage complex cross products: magnetic determinant and four numerators.
// Depends on itff_pkg.
module itff_cross (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	input  logic [itff_pkg::FIELD_W-1:0]           ex_pol1,
	input  logic [itff_pkg::FIELD_W-1:0]           ex_pol2,
	input  logic [itff_pkg::FIELD_W-1:0]           ey_pol1,
	input  logic [itff_pkg::FIELD_W-1:0]           ey_pol2,
	input  logic [itff_pkg::FIELD_W-1:0]           hx_pol1,
	input  logic [itff_pkg::FIELD_W-1:0]           hx_pol2,
	input  logic [itff_pkg::FIELD_W-1:0]           hy_pol1,
	input  logic [itff_pkg::FIELD_W-1:0]           hy_pol2,
	output logic                                   out_valid,
	output itff_pkg::cwide_t                       det,
	output itff_pkg::cwide_t [3:0]                 num
);

	localparam int NPAIR = 10;
	localparam int NTERM = 5;
	localparam int HW = itff_pkg::HALF_W;
	localparam int PW = 2 * itff_pkg::HALF_W;

	typedef struct packed {
		logic signed [PW-1:0] rr;
		logic signed [PW-1:0] ii;
		logic signed [PW-1:0] ri;
		logic signed [PW-1:0] ir;
	} prod4_t;

	logic [itff_pkg::FIELD_W-1:0] op_a [NPAIR];
	logic [itff_pkg::FIELD_W-1:0] op_b [NPAIR];
	prod4_t prod_s1 [NPAIR];
	logic valid_s1;
	itff_pkg::cwide_t term_s2 [NTERM];
	logic valid_s2;

	// even pair minus odd pair gives one term: det, xx, xy, yx, yy
	always_comb begin
		op_a[0] = hx_pol1; op_b[0] = hy_pol2;
		op_a[1] = hy_pol1; op_b[1] = hx_pol2;
		op_a[2] = ex_pol1; op_b[2] = hy_pol2;
		op_a[3] = hy_pol1; op_b[3] = ex_pol2;
		op_a[4] = ex_pol2; op_b[4] = hx_pol1;
		op_a[5] = hx_pol2; op_b[5] = ex_pol1;
		op_a[6] = ey_pol1; op_b[6] = hy_pol2;
		op_a[7] = hy_pol1; op_b[7] = ey_pol2;
		op_a[8] = ey_pol2; op_b[8] = hx_pol1;
		op_a[9] = hx_pol2; op_b[9] = ey_pol1;
	end

	always_ff @(posedge clk) begin
		for (int p = 0; p < NPAIR; p++) begin
			prod_s1[p].rr <= signed'(op_a[p][PW-1:HW]) * signed'(op_b[p][PW-1:HW]);
			prod_s1[p].ii <= signed'(op_a[p][HW-1:0]) * signed'(op_b[p][HW-1:0]);
			prod_s1[p].ri <= signed'(op_a[p][PW-1:HW]) * signed'(op_b[p][HW-1:0]);
			prod_s1[p].ir <= signed'(op_a[p][HW-1:0]) * signed'(op_b[p][PW-1:HW]);
		end
	end

	always_ff @(posedge clk) begin
		for (int t = 0; t < NTERM; t++) begin
			term_s2[t].re <= itff_pkg::SUM_W'(prod_s1[2*t].rr)
				- itff_pkg::SUM_W'(prod_s1[2*t].ii)
				- itff_pkg::SUM_W'(prod_s1[2*t+1].rr)
				+ itff_pkg::SUM_W'(prod_s1[2*t+1].ii);
			term_s2[t].im <= itff_pkg::SUM_W'(prod_s1[2*t].ri)
				+ itff_pkg::SUM_W'(prod_s1[2*t].ir)
				- itff_pkg::SUM_W'(prod_s1[2*t+1].ri)
				- itff_pkg::SUM_W'(prod_s1[2*t+1].ir);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	assign out_valid = valid_s2;
	assign det = term_s2[0];
	assign num[0] = term_s2[1];
	assign num[1] = term_s2[2];
	assign num[2] = term_s2[3];
	assign num[3] = term_s2[4];

endmodule

// File: rtl/itff_wmul.sv
// 66 x 66 signed multiply split into four ~33-bit partial products, two stages.
// Depends on itff_pkg.
module itff_wmul (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic signed [itff_pkg::SUM_W-1:0]   a,
	input  logic signed [itff_pkg::SUM_W-1:0]   b,
	output logic                                out_valid,
	output logic signed [itff_pkg::PROD_W-1:0]  p
);

	localparam int HW = itff_pkg::HALF_W;
	localparam int SW = itff_pkg::SUM_W;
	localparam int PW = itff_pkg::PROD_W;

	logic signed [SW-HW-1:0] a_hi, b_hi;
	logic signed [HW:0] a_lo, b_lo;
	logic signed [2*(SW-HW)-1:0] hh_s1;
	logic signed [SW:0] hl_s1, lh_s1;
	logic [2*HW-1:0] ll_s1;
	logic valid_s1;
	logic signed [PW-1:0] p_s2;
	logic valid_s2;

	assign a_hi = a[SW-1:HW];
	assign b_hi = b[SW-1:HW];
	assign a_lo = {1'b0, a[HW-1:0]};
	assign b_lo = {1'b0, b[HW-1:0]};

	always_ff @(posedge clk) begin
		hh_s1 <= a_hi * b_hi;
		hl_s1 <= a_hi * b_lo;
		lh_s1 <= a_lo * b_hi;
		ll_s1 <= a[HW-1:0] * b[HW-1:0];
	end

	always_ff @(posedge clk) begin
		p_s2 <= (PW'(hh_s1) <<< (2*HW)) + (PW'(hl_s1) <<< HW) + (PW'(lh_s1) <<< HW)
			+ PW'(ll_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	assign out_valid = valid_s2;
	assign p = p_s2;

endmodule

// File: rtl/itff_div.sv
// Pipelined restoring divider for one output component: round(|x| * 2^frac / den),
// saturation to CW bits and sign. One quotient bit per stage. Depends on itff_pkg.
module itff_div #(
	parameter int CW = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic [itff_pkg::FRAC_W-1:0]        frac,
	input  logic signed [itff_pkg::X_W-1:0]    x,
	input  logic [itff_pkg::MAG_W-1:0]         den,
	output logic                               out_valid,
	output logic [itff_pkg::HALF_W-1:0]        res,
	output logic                               over,
	output logic                               zero
);

	localparam int MW = itff_pkg::MAG_W;
	localparam int DW = itff_pkg::DIV_W;

	logic [MW-1:0] mag_s1, den_s1;
	logic neg_s1, zero_s1, valid_s1;

	// index 0 is the shifted dividend, index i+1 follows quotient step i
	logic [DW-1:0] rem_s [CW+1];
	logic [CW-1:0] q_s [CW+1];
	logic [MW-1:0] den_s [CW+1];
	logic neg_s [CW+1];
	logic zero_s [CW+1];
	logic over_s [CW+1];
	logic valid_s [CW+1];

	logic rnd;
	logic [CW:0] qr_r1;
	logic neg_r1, zero_r1, over_r1, valid_r1;

	logic [CW:0] limit;
	logic sat;
	logic [CW:0] val;
	logic signed [CW-1:0] sres;
	logic [itff_pkg::HALF_W-1:0] res_r2;
	logic over_r2, zero_r2, valid_r2;

	always_ff @(posedge clk) begin
		mag_s1 <= x[itff_pkg::X_W-1] ? MW'(-x) : MW'(x);
		neg_s1 <= x[itff_pkg::X_W-1];
		den_s1 <= den;
		zero_s1 <= (den == '0);
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= DW'(mag_s1) << frac;
		q_s[0] <= '0;
		den_s[0] <= den_s1;
		neg_s[0] <= neg_s1;
		zero_s[0] <= zero_s1;
		over_s[0] <= 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s[0] <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s[0] <= valid_s1;
		end
	end

	for (genvar i = 0; i < CW; i++) begin : g_step
		localparam int K = CW - 1 - i;
		logic [DW-1:0] dsh;
		logic ge, big;

		assign dsh = DW'(den_s[i]) << K;
		assign ge = (rem_s[i] >= dsh);
		// first step also flags a quotient of 2^CW or more
		if (i == 0) begin : g_big
			assign big = (rem_s[i] >= (DW'(den_s[i]) << CW));
		end else begin : g_nobig
			assign big = 1'b0;
		end

		always_ff @(posedge clk) begin
			rem_s[i+1] <= ge ? rem_s[i] - dsh : rem_s[i];
			q_s[i+1] <= q_s[i] | (CW'(ge) << K);
			den_s[i+1] <= den_s[i];
			neg_s[i+1] <= neg_s[i];
			zero_s[i+1] <= zero_s[i];
			over_s[i+1] <= over_s[i] | big;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i+1] <= 1'b0;
			end else begin
				valid_s[i+1] <= valid_s[i];
			end
		end
	end

	// round half away from zero on the magnitude
	assign rnd = ((DW+1)'(rem_s[CW]) << 1) >= (DW+1)'(den_s[CW]);

	always_ff @(posedge clk) begin
		qr_r1 <= (CW+1)'(q_s[CW]) + (CW+1)'(rnd);
		neg_r1 <= neg_s[CW];
		zero_r1 <= zero_s[CW];
		over_r1 <= over_s[CW];
	end

	always_comb begin
		limit = ((CW+1)'(1) << (CW - 1)) - (CW+1)'(!neg_r1);
		sat = over_r1 || (qr_r1 > limit);
		val = sat ? limit : qr_r1;
		sres = neg_r1 ? -signed'(val[CW-1:0]) : signed'(val[CW-1:0]);
	end

	always_ff @(posedge clk) begin
		res_r2 <= zero_r1 ? '0 : itff_pkg::HALF_W'(sres);
		over_r2 <= sat && !zero_r1;
		zero_r2 <= zero_r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_r1 <= 1'b0;
			valid_r2 <= 1'b0;
		end else begin
			valid_r1 <= valid_s[CW];
			valid_r2 <= valid_r1;
		end
	end

	assign out_valid = valid_r2;
	assign res = res_r2;
	assign over = over_r2;
	assign zero = zero_r2;

endmodule

// File: rtl/impedance_tensor_from_fields_unit.sv
// Impedance tensor Z = E * inv(H) from two-polarization field spectra, one bin per request.
// Pipeline: 2 cross-product stages, 2 wide-multiply stages, 1 sum stage and a divider with
// one stage per quotient bit plus 4. Throughput one request per clock; busy is never raised
// and done pulses for one cycle per result.
// arst_n clears all valid bits and sets frac_q to 16.
// Depends on itff_pkg, itff_cross, itff_wmul, itff_div.
module impedance_tensor_from_fields_unit #(
	parameter int COMPONENT_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [itff_pkg::FIELD_W-1:0]       ex_pol1,
	input  logic [itff_pkg::FIELD_W-1:0]       ex_pol2,
	input  logic [itff_pkg::FIELD_W-1:0]       ey_pol1,
	input  logic [itff_pkg::FIELD_W-1:0]       ey_pol2,
	input  logic [itff_pkg::FIELD_W-1:0]       hx_pol1,
	input  logic [itff_pkg::FIELD_W-1:0]       hx_pol2,
	input  logic [itff_pkg::FIELD_W-1:0]       hy_pol1,
	input  logic [itff_pkg::FIELD_W-1:0]       hy_pol2,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [itff_pkg::FRAC_W-1:0]        cfg_data,
	output logic                               done,
	output logic [itff_pkg::FIELD_W-1:0]       z_xx,
	output logic [itff_pkg::FIELD_W-1:0]       z_xy,
	output logic [itff_pkg::FIELD_W-1:0]       z_yx,
	output logic [itff_pkg::FIELD_W-1:0]       z_yy,
	output logic                               singular,
	output logic                               saturated
);

	localparam int NEL = 4;
	localparam int XW = itff_pkg::X_W;
	localparam int LATENCY = COMPONENT_WIDTH + 9;

	logic [itff_pkg::FRAC_W-1:0] frac_q;
	logic cross_valid;
	itff_pkg::cwide_t det;
	itff_pkg::cwide_t [NEL-1:0] num;

	logic mul_valid;
	logic signed [itff_pkg::PROD_W-1:0] dd_re, dd_im;
	logic signed [itff_pkg::PROD_W-1:0] p_rr [NEL];
	logic signed [itff_pkg::PROD_W-1:0] p_ii [NEL];
	logic signed [itff_pkg::PROD_W-1:0] p_ir [NEL];
	logic signed [itff_pkg::PROD_W-1:0] p_ri [NEL];

	logic [itff_pkg::MAG_W-1:0] den_s1;
	logic signed [XW-1:0] xre_s1 [NEL];
	logic signed [XW-1:0] xim_s1 [NEL];
	logic valid_s1;

	logic [itff_pkg::HALF_W-1:0] res_re [NEL];
	logic [itff_pkg::HALF_W-1:0] res_im [NEL];
	logic [NEL-1:0] over_re, over_im;
	logic div_valid, div_zero;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_q <= itff_pkg::FRAC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			frac_q <= cfg_data;
		end
	end

	itff_cross u_cross (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.ex_pol1   (ex_pol1),
		.ex_pol2   (ex_pol2),
		.ey_pol1   (ey_pol1),
		.ey_pol2   (ey_pol2),
		.hx_pol1   (hx_pol1),
		.hx_pol2   (hx_pol2),
		.hy_pol1   (hy_pol1),
		.hy_pol2   (hy_pol2),
		.out_valid (cross_valid),
		.det       (det),
		.num       (num)
	);

	itff_wmul u_dd_re (
		.clk (clk), .arst_n (arst_n), .in_valid (cross_valid),
		.a (det.re), .b (det.re), .out_valid (mul_valid), .p (dd_re)
	);

	itff_wmul u_dd_im (
		.clk (clk), .arst_n (arst_n), .in_valid (cross_valid),
		.a (det.im), .b (det.im), .out_valid (), .p (dd_im)
	);

	// N * conj(D): re = Nr*Dr + Ni*Di, im = Ni*Dr - Nr*Di
	for (genvar n = 0; n < NEL; n++) begin : g_mul
		itff_wmul u_rr (
			.clk (clk), .arst_n (arst_n), .in_valid (cross_valid),
			.a (num[n].re), .b (det.re), .out_valid (), .p (p_rr[n])
		);
		itff_wmul u_ii (
			.clk (clk), .arst_n (arst_n), .in_valid (cross_valid),
			.a (num[n].im), .b (det.im), .out_valid (), .p (p_ii[n])
		);
		itff_wmul u_ir (
			.clk (clk), .arst_n (arst_n), .in_valid (cross_valid),
			.a (num[n].im), .b (det.re), .out_valid (), .p (p_ir[n])
		);
		itff_wmul u_ri (
			.clk (clk), .arst_n (arst_n), .in_valid (cross_valid),
			.a (num[n].re), .b (det.im), .out_valid (), .p (p_ri[n])
		);
	end

	always_ff @(posedge clk) begin
		den_s1 <= itff_pkg::MAG_W'(dd_re + dd_im);
		for (int n = 0; n < NEL; n++) begin
			xre_s1[n] <= XW'(p_rr[n]) + XW'(p_ii[n]);
			xim_s1[n] <= XW'(p_ir[n]) - XW'(p_ri[n]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= mul_valid;
		end
	end

	for (genvar n = 0; n < NEL; n++) begin : g_div
		if (n == 0) begin : g_lead
			itff_div #(.CW (COMPONENT_WIDTH)) u_re (
				.clk (clk), .arst_n (arst_n), .in_valid (valid_s1), .frac (frac_q),
				.x (xre_s1[n]), .den (den_s1), .out_valid (div_valid),
				.res (res_re[n]), .over (over_re[n]), .zero (div_zero)
			);
		end else begin : g_rest
			itff_div #(.CW (COMPONENT_WIDTH)) u_re (
				.clk (clk), .arst_n (arst_n), .in_valid (valid_s1), .frac (frac_q),
				.x (xre_s1[n]), .den (den_s1), .out_valid (),
				.res (res_re[n]), .over (over_re[n]), .zero ()
			);
		end
		itff_div #(.CW (COMPONENT_WIDTH)) u_im (
			.clk (clk), .arst_n (arst_n), .in_valid (valid_s1), .frac (frac_q),
			.x (xim_s1[n]), .den (den_s1), .out_valid (),
			.res (res_im[n]), .over (over_im[n]), .zero ()
		);
	end

	assign done = div_valid;
	assign z_xx = {res_re[0], res_im[0]};
	assign z_xy = {res_re[1], res_im[1]};
	assign z_yx = {res_re[2], res_im[2]};
	assign z_yy = {res_re[3], res_im[3]};
	assign singular = div_zero;
	assign saturated = (|over_re) || (|over_im);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("accepted request did not complete at the pipeline latency");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result strobe without a matching request");

	a_singular: assert property (@(posedge clk) disable iff (!arst_n)
		(done && singular) |-> (z_xx == '0 && z_xy == '0 && z_yx == '0 && z_yy == '0
			&& !saturated))
		else $error("singular result carries nonzero tensor or saturation");

endmodule
